/* rtl/tfn_pkg.sv */
package tfn_pkg;

  localparam int DEPTH  = 4096;
  localparam int IDX_W  = 12;
  localparam int COORD_W = 24;
  localparam int VERT_W = 3 * COORD_W;
  localparam int EDGE_W = COORD_W + 1;
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 101;
  localparam int N_W    = 50;
  localparam int SQ_W   = 98;
  localparam int LEN_W  = 100;
  localparam int WIDE_W = 131;
  localparam int Q_W    = 15;
  localparam int OUT_W  = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FACE = 1'b1;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_25 = 2'd1;
  localparam logic [1:0] SH_48 = 2'd2;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic [1:0] sh;
    logic       wr_n;
    logic       wr_sq;
    logic [1:0] dst;
  } mac_ctl_t;

endpackage

/* rtl/triangle_face_normal_core.sv */
// Face normal unit with a 4096-entry vertex store. A load (cmd 0) writes one
// vertex in the cycle it is accepted and busy never rises. A face (cmd 1)
// keeps busy high while it reads the three corners from the single store
// port, forms the edge vectors, runs the cross product and squares on one
// shared 26x26 multiply-accumulate (15 issues and one drain), sums and tests
// the squared length, and performs the three normalizations, each of which
// finds 15 quotient bits, one per pass through DIVA and DIVB, on one 131-bit
// add/compare unit. A degenerate face skips the normalizations. The
// result is shown for exactly one cycle with done high, in the first cycle
// that busy is low; the receiver cannot stall it and must take it then.
module triangle_face_normal_core
  import tfn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd,
  input  logic [IDX_W-1:0]          vertex_slot,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [IDX_W-1:0]          first_corner,
  input  logic [IDX_W-1:0]          second_corner,
  input  logic [IDX_W-1:0]          third_corner,
  output logic                      done,
  output logic signed [OUT_W-1:0]   normal_x,
  output logic signed [OUT_W-1:0]   normal_y,
  output logic signed [OUT_W-1:0]   normal_z,
  output logic                      degenerate
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EDGE  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_DIVA  = 3'd6;
  localparam logic [2:0] ST_DIVB  = 3'd7;

  logic [2:0] state;
  logic [1:0] rd_cnt;
  logic [3:0] step;
  logic [3:0] bit_idx;
  logic [1:0] comp;
  logic       chk;

  logic [VERT_W-1:0] vstore [DEPTH];
  logic [VERT_W-1:0] mem_q;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  idx_a, idx_b, idx_c;
  logic [VERT_W-1:0] va, vb, vc;

  logic signed [EDGE_W-1:0] ab [3];
  logic signed [EDGE_W-1:0] ac [3];
  logic signed [N_W-1:0]    nv [3];
  logic [SQ_W-1:0]          sq [3];
  logic [LEN_W-1:0]         len2;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_w, prod_r;
  mac_ctl_t                 ctl, ctl_r;
  logic signed [ACC_W-1:0]  acc, acc_next, term;
  logic [N_W-1:0]           nmag [3];
  logic [MUL_W-1:0]         hi_p [3];
  logic [MUL_W-1:0]         lo_p [3];

  logic [WIDE_W-1:0] t_acc, d_acc, ls, s_sum, trial, target;
  logic [Q_W-1:0]    q, q_next;
  logic              fit;
  logic signed [OUT_W-1:0] res;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (start && !busy && cmd == CMD_LOAD) begin
      vstore[vertex_slot] <= {coord_z, coord_y, coord_x};
    end
    mem_q <= vstore[rd_addr];
  end

  always_comb begin
    unique case (rd_cnt)
      2'd0:    rd_addr = idx_a;
      2'd1:    rd_addr = idx_b;
      default: rd_addr = idx_c;
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign nmag[k] = nv[k][N_W-1] ? N_W'(-nv[k]) : N_W'(nv[k]);
    assign hi_p[k] = {1'b0, nmag[k][48:24]};
    assign lo_p[k] = {2'b00, nmag[k][23:0]};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ctl   = '0;
    if (state == ST_MAC) begin
      ctl.vld = 1'b1;
      unique case (step)
        4'd0:  begin mul_a = MUL_W'(ab[1]); mul_b = MUL_W'(ac[2]); ctl.clr = 1'b1; end
        4'd1:  begin
          mul_a = MUL_W'(ab[2]); mul_b = MUL_W'(ac[1]);
          ctl.neg = 1'b1; ctl.wr_n = 1'b1; ctl.dst = 2'd0;
        end
        4'd2:  begin mul_a = MUL_W'(ab[2]); mul_b = MUL_W'(ac[0]); ctl.clr = 1'b1; end
        4'd3:  begin
          mul_a = MUL_W'(ab[0]); mul_b = MUL_W'(ac[2]);
          ctl.neg = 1'b1; ctl.wr_n = 1'b1; ctl.dst = 2'd1;
        end
        4'd4:  begin mul_a = MUL_W'(ab[0]); mul_b = MUL_W'(ac[1]); ctl.clr = 1'b1; end
        4'd5:  begin
          mul_a = MUL_W'(ab[1]); mul_b = MUL_W'(ac[0]);
          ctl.neg = 1'b1; ctl.wr_n = 1'b1; ctl.dst = 2'd2;
        end
        4'd6:  begin
          mul_a = hi_p[0]; mul_b = hi_p[0]; ctl.clr = 1'b1; ctl.sh = SH_48;
        end
        4'd7:  begin mul_a = hi_p[0]; mul_b = lo_p[0]; ctl.sh = SH_25; end
        4'd8:  begin
          mul_a = lo_p[0]; mul_b = lo_p[0]; ctl.wr_sq = 1'b1; ctl.dst = 2'd0;
        end
        4'd9:  begin
          mul_a = hi_p[1]; mul_b = hi_p[1]; ctl.clr = 1'b1; ctl.sh = SH_48;
        end
        4'd10: begin mul_a = hi_p[1]; mul_b = lo_p[1]; ctl.sh = SH_25; end
        4'd11: begin
          mul_a = lo_p[1]; mul_b = lo_p[1]; ctl.wr_sq = 1'b1; ctl.dst = 2'd1;
        end
        4'd12: begin
          mul_a = hi_p[2]; mul_b = hi_p[2]; ctl.clr = 1'b1; ctl.sh = SH_48;
        end
        4'd13: begin mul_a = hi_p[2]; mul_b = lo_p[2]; ctl.sh = SH_25; end
        4'd14: begin
          mul_a = lo_p[2]; mul_b = lo_p[2]; ctl.wr_sq = 1'b1; ctl.dst = 2'd2;
        end
        default: ctl.vld = 1'b0;
      endcase
    end
  end

  assign prod_w = mul_a * mul_b;

  always_comb begin
    term = ACC_W'(prod_r);
    unique case (ctl_r.sh)
      SH_25:   term = term <<< 25;
      SH_48:   term = term <<< 48;
      default: term = ACC_W'(prod_r);
    endcase
    acc_next = (ctl_r.clr ? ACC_W'(0) : acc) + (ctl_r.neg ? -term : term);
  end

  assign target = {5'd0, sq[comp], 28'd0};
  assign trial  = t_acc + s_sum;
  assign fit    = (trial <= target);

  always_comb begin
    q_next = q;
    if (fit) begin
      q_next[bit_idx] = 1'b1;
    end
  end

  assign res = nv[comp][N_W-1] ? -OUT_W'(q_next) : OUT_W'(q_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ctl_r  <= '0;
      done   <= 1'b0;
      rd_cnt <= '0;
      step   <= '0;
      chk    <= 1'b0;
    end else begin
      done   <= 1'b0;
      ctl_r  <= ctl;
      prod_r <= prod_w;
      if (ctl_r.vld) begin
        acc <= acc_next;
        if (ctl_r.wr_n) begin
          nv[ctl_r.dst] <= acc_next[N_W-1:0];
        end
        if (ctl_r.wr_sq) begin
          sq[ctl_r.dst] <= acc_next[SQ_W-1:0];
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (start && cmd == CMD_FACE) begin
            idx_a  <= first_corner;
            idx_b  <= second_corner;
            idx_c  <= third_corner;
            rd_cnt <= '0;
            state  <= ST_RD;
          end
        end
        ST_RD: begin
          rd_cnt <= rd_cnt + 2'd1;
          unique case (rd_cnt)
            2'd1:    va <= mem_q;
            2'd2:    vb <= mem_q;
            2'd3:    begin vc <= mem_q; state <= ST_EDGE; end
            default: ;
          endcase
        end
        ST_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            ab[k] <= EDGE_W'($signed(vb[k*COORD_W +: COORD_W]))
                   - EDGE_W'($signed(va[k*COORD_W +: COORD_W]));
            ac[k] <= EDGE_W'($signed(vc[k*COORD_W +: COORD_W]))
                   - EDGE_W'($signed(va[k*COORD_W +: COORD_W]));
          end
          step  <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          step <= step + 4'd1;
          if (step == 4'd14) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          chk   <= 1'b0;
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (!chk) begin
            len2 <= LEN_W'(sq[0]) + LEN_W'(sq[1]) + LEN_W'(sq[2]);
            chk  <= 1'b1;
          end else if (len2 == '0) begin
            normal_x   <= '0;
            normal_y   <= '0;
            normal_z   <= '0;
            degenerate <= 1'b1;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            comp    <= 2'd0;
            t_acc   <= '0;
            d_acc   <= '0;
            ls      <= WIDE_W'(len2) << 28;
            q       <= '0;
            bit_idx <= 4'd14;
            state   <= ST_DIVA;
          end
        end
        ST_DIVA: begin
          s_sum <= d_acc + ls;
          state <= ST_DIVB;
        end
        ST_DIVB: begin
          if (fit) begin
            t_acc <= trial;
            d_acc <= (d_acc >> 1) + ls;
          end else begin
            d_acc <= d_acc >> 1;
          end
          ls      <= ls >> 2;
          q       <= q_next;
          bit_idx <= bit_idx - 4'd1;
          state   <= ST_DIVA;
          if (bit_idx == 4'd0) begin
            t_acc   <= '0;
            d_acc   <= '0;
            ls      <= WIDE_W'(len2) << 28;
            q       <= '0;
            bit_idx <= 4'd14;
            comp    <= comp + 2'd1;
            unique case (comp)
              2'd0:    normal_x <= res;
              2'd1:    normal_y <= res;
              default: begin
                normal_z   <= res;
                degenerate <= 1'b0;
                done       <= 1'b1;
                state      <= ST_IDLE;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
    else $error("degenerate beat with nonzero normal");
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_LOAD) |=> !busy)
    else $error("load held the block busy");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16384 && normal_x >= -16384))
    else $error("normal out of range");
`endif

endmodule

/* tb/triangle_face_normal_core_tb.sv */
`timescale 1ns / 100ps

module triangle_face_normal_core_tb;
  import tfn_pkg::*;

  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          slot;
    logic signed [COORD_W-1:0] px, py, pz;
    logic [IDX_W-1:0]          ca, cb, cc;
  } beat_t;

  typedef struct {
    logic signed [OUT_W-1:0] nx, ny, nz;
    logic                    deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_LOAD;
  logic [IDX_W-1:0] vertex_slot = '0;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [IDX_W-1:0] first_corner = '0, second_corner = '0, third_corner = '0;
  logic done;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
  logic degenerate;

  triangle_face_normal_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t   pending_q[$];
  normal_t normal_q[$];
  logic signed [COORD_W-1:0] shadow_x[DEPTH], shadow_y[DEPTH], shadow_z[DEPTH];
  logic signed [COORD_W-1:0] plan_x[DEPTH], plan_y[DEPTH], plan_z[DEPTH];
  bit      plan_valid[DEPTH];
  int      written_slots[$];
  int      mismatches = 0;
  int      faces_done = 0, degen_seen = 0, loads_done = 0;
  logic    taken = 1'b0;
  int      gap_left = 0;

  function automatic logic [15:0] unit_q14(longint n, logic [255:0] len2);
    logic [255:0] mag, target, trial;
    int lo, hi, mid;
    mag = 256'((n < 0) ? -n : n);
    target = (mag * mag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      trial = len2 * mid * mid;
      if (trial <= target) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(int ia, int ib, int ic);
    longint ab[3], ac[3], n[3];
    logic [255:0] len2;
    normal_t r;
    ab[0] = longint'(shadow_x[ib]) - longint'(shadow_x[ia]);
    ab[1] = longint'(shadow_y[ib]) - longint'(shadow_y[ia]);
    ab[2] = longint'(shadow_z[ib]) - longint'(shadow_z[ia]);
    ac[0] = longint'(shadow_x[ic]) - longint'(shadow_x[ia]);
    ac[1] = longint'(shadow_y[ic]) - longint'(shadow_y[ia]);
    ac[2] = longint'(shadow_z[ic]) - longint'(shadow_z[ia]);
    n[0] = ab[1] * ac[2] - ab[2] * ac[1];
    n[1] = ab[2] * ac[0] - ab[0] * ac[2];
    n[2] = ab[0] * ac[1] - ab[1] * ac[0];
    len2 = '0;
    for (int k = 0; k < 3; k++)
      len2 += 256'((n[k] < 0) ? -n[k] : n[k]) * 256'((n[k] < 0) ? -n[k] : n[k]);
    if (len2 == 0) begin
      r = '{0, 0, 0, 1'b1};
    end else begin
      r.nx = unit_q14(n[0], len2);
      r.ny = unit_q14(n[1], len2);
      r.nz = unit_q14(n[2], len2);
      r.deg = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? COORD_W'(24'sh7FFFFF - $urandom_range(15))
                                  : COORD_W'(24'sh800000 + $urandom_range(15));
      1, 2: return COORD_W'($signed($urandom_range(8191)) - 4096);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic beat_t load_beat(int s, logic signed [COORD_W-1:0] x, y, z);
    beat_t b;
    b = '{CMD_LOAD, IDX_W'(s), x, y, z,
          IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom)};
    return b;
  endfunction

  function automatic beat_t face_beat(int a, b, c);
    beat_t f;
    f = '{CMD_FACE, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
          COORD_W'($urandom), IDX_W'(a), IDX_W'(b), IDX_W'(c)};
    return f;
  endfunction

  function automatic int pick_slot();
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  function automatic void queue_beat(beat_t b);
    pending_q = {pending_q, b};
    if (b.op == CMD_LOAD) begin
      if (!plan_valid[b.slot]) written_slots = {written_slots, int'(b.slot)};
      plan_valid[b.slot] = 1'b1;
      plan_x[b.slot] = b.px;
      plan_y[b.slot] = b.py;
      plan_z[b.slot] = b.pz;
    end
  endfunction

  initial begin
    int s, src;
    queue_beat(load_beat(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    queue_beat(load_beat(4095, 24'sh800000, 24'sh800000, 24'sh800000));
    queue_beat(load_beat(1, 24'sh7FFFFF, 24'sh800000, 24'sd0));
    queue_beat(load_beat(2, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF));
    queue_beat(load_beat(2730, 24'sd0, 24'sd0, 24'sd0));
    queue_beat(load_beat(1365, 24'sh001000, 24'sd0, 24'sd0));
    queue_beat(load_beat(2048, 24'sd0, 24'sh001000, 24'sd0));
    queue_beat(load_beat(3, 24'sd0, 24'sd0, 24'sh001000));
    queue_beat(load_beat(4, 24'sh002000, 24'sh002000, 24'sh002000));
    queue_beat(load_beat(5, 24'sd1, -24'sd1, 24'sd1));
    queue_beat(face_beat(2730, 1365, 2048));
    queue_beat(face_beat(2730, 2048, 1365));
    queue_beat(face_beat(2730, 1365, 3));
    queue_beat(face_beat(2730, 0, 4));
    queue_beat(face_beat(0, 0, 0));
    queue_beat(face_beat(0, 4095, 1));
    queue_beat(face_beat(4095, 0, 2));
    queue_beat(face_beat(1, 2, 4095));
    queue_beat(face_beat(2730, 1365, 1365));
    queue_beat(face_beat(2730, 5, 1365));
    queue_beat(face_beat(4095, 1, 2));
    for (int i = 0; i < 1350; i++) begin
      if (written_slots.size() < 40 || $urandom_range(99) < 35) begin
        s = $urandom_range(DEPTH - 1);
        if ($urandom_range(9) == 0)
          s = pick_slot();
        if ($urandom_range(9) == 0) begin
          src = pick_slot();
          queue_beat(load_beat(s, -plan_x[src], -plan_y[src], -plan_z[src]));
        end else begin
          queue_beat(load_beat(s, rand_coord(), rand_coord(), rand_coord()));
        end
      end else if ($urandom_range(19) == 0) begin
        s = pick_slot();
        queue_beat(face_beat(s, pick_slot(), s));
      end else begin
        queue_beat(face_beat(pick_slot(), pick_slot(), pick_slot()));
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !taken) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        beat_t b;
        b = pending_q.pop_front();
        start <= 1'b1;
        cmd <= b.op;
        vertex_slot <= b.slot;
        coord_x <= b.px;
        coord_y <= b.py;
        coord_z <= b.pz;
        first_corner <= b.ca;
        second_corner <= b.cb;
        third_corner <= b.cc;
        if ($urandom_range(9) < 6) gap_left <= 0;
        else if ($urandom_range(14) == 0) gap_left <= $urandom_range(60, 20);
        else gap_left <= $urandom_range(4, 1);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    taken <= start && !busy && !rst;
    if (!rst && start && !busy) begin
      if (cmd == CMD_LOAD) begin
        shadow_x[vertex_slot] = coord_x;
        shadow_y[vertex_slot] = coord_y;
        shadow_z[vertex_slot] = coord_z;
        loads_done++;
      end else begin
        normal_q = {normal_q, face_normal(int'(first_corner), int'(second_corner),
                                          int'(third_corner))};
      end
    end
    if (!rst && done) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal beat at %0t", $realtime);
      end else begin
        normal_t e;
        e = normal_q.pop_front();
        faces_done++;
        if (e.deg) degen_seen++;
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
            degenerate !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected (%0d %0d %0d deg %0b) got (%0d %0d %0d deg %0b)",
                     e.nx, e.ny, e.nz, e.deg, normal_x, normal_y, normal_z, degenerate);
        end
      end
    end
  end

  initial begin
    wait (!rst);
    wait (pending_q.size() == 0 && !start);
    wait (normal_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d vertex loads and %0d faces checked, %0d of them degenerate",
             loads_done, faces_done, degen_seen);
    if (mismatches == 0 && normal_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/tfn_pkg.sv
rtl/triangle_face_normal_core.sv
tb/triangle_face_normal_core_tb.sv
